// File: hw/rtl/tscb_pkg.sv
// ----------------------------------------------------------------------------
// tscb_pkg
// Shared types and constants for the two-stack cursor text buffer.
// ----------------------------------------------------------------------------
package tscb_pkg;

    localparam int DEPTH_DEF = 1024;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 11;
    localparam int POS_W   = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BACKSPACE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE      = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_FETCH,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/tscb_ram.sv
// ----------------------------------------------------------------------------
// tscb_ram
// One character stack store: one write port and one read port with a
// registered read that holds its data while no read is issued.
// ----------------------------------------------------------------------------
module tscb_ram #(
    parameter int DEPTH = tscb_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tscb_pkg::CHAR_W-1:0] i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tscb_pkg::CHAR_W-1:0] o_rdata
);
    import tscb_pkg::*;

    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/two_stack_cursor_text_buffer_unit.sv
// ----------------------------------------------------------------------------
// two_stack_cursor_text_buffer_unit
// One line of text kept as two stacks that meet at the cursor.
//
// The input channel carries one command per beat (insert, delete after the
// cursor, backspace, or move the cursor to an absolute position). The output
// channel returns one result beat per command with a status, both counts and
// the characters on either side of the cursor.
// Insert, delete and backspace go from acceptance through ST_FETCH, which
// reads both stores, to ST_DONE, which loads the output register; no new
// command is accepted until the unit is back in ST_IDLE. A valid move first
// runs ST_MOVE, shifting one character per cycle between the two stack
// memories by streaming a read of one store into a write of the other.
// Reset clears both fill counts and the output valid flag; the memory
// contents are never cleared, as only entries below the fill counts are read.
// While the receiver stalls, the result is held in the output register and
// one further command may be accepted and worked off; its result then waits
// until the output register is taken.
// ----------------------------------------------------------------------------
module two_stack_cursor_text_buffer_unit #(
    parameter int DEPTH = tscb_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tscb_pkg::CMD_W-1:0]   i_command,
    input  logic [tscb_pkg::CHAR_W-1:0]  i_char_in,
    input  logic [tscb_pkg::POS_W-1:0]   i_position,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tscb_pkg::STAT_W-1:0]  o_status,
    output logic [tscb_pkg::COUNT_W-1:0] o_left_count,
    output logic [tscb_pkg::COUNT_W-1:0] o_right_count,
    output logic [tscb_pkg::CHAR_W-1:0]  o_char_before,
    output logic [tscb_pkg::CHAR_W-1:0]  o_char_after
);
    import tscb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int TW = FW + 1 + POS_W;
    localparam logic [FW-1:0] ONE = {{(FW-1){1'b0}}, 1'b1};
    localparam logic [TW-1:0] DEPTH_T = TW'(DEPTH);

    t_state              r_state, n_state;
    logic [FW-1:0]       r_lf, n_lf;
    logic [FW-1:0]       r_rf, n_rf;
    logic [FW-1:0]       r_tgt, n_tgt;
    logic                r_pend, n_pend;
    logic                r_dir_right, n_dir_right;
    logic [STAT_W-1:0]   r_status, n_status;

    logic                r_out_valid, n_out_valid;
    logic [STAT_W-1:0]   r_out_status, n_out_status;
    logic [COUNT_W-1:0]  r_out_lc, n_out_lc;
    logic [COUNT_W-1:0]  r_out_rc, n_out_rc;
    logic [CHAR_W-1:0]   r_out_cb, n_out_cb;
    logic [CHAR_W-1:0]   r_out_ca, n_out_ca;

    logic                accept;
    logic                load_out;
    logic [TW-1:0]       total_t;
    logic [TW-1:0]       pos_t;
    logic [FW-1:0]       lf_m1, rf_m1;
    logic [FW-1:0]       lf_eff, rf_eff;
    logic [FW-1:0]       lf_eff_m1, rf_eff_m1;
    logic [FW+COUNT_W-1:0] lf_ext, rf_ext;

    logic                l_we, l_re, rs_we, rs_re;
    logic [AW-1:0]       l_waddr, l_raddr, rs_waddr, rs_raddr;
    logic [CHAR_W-1:0]   l_wdata, rs_wdata, l_rdata, rs_rdata;

    tscb_ram #(.DEPTH(DEPTH), .AW(AW)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (l_re),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    tscb_ram #(.DEPTH(DEPTH), .AW(AW)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (rs_we),
        .i_waddr (rs_waddr),
        .i_wdata (rs_wdata),
        .i_re    (rs_re),
        .i_raddr (rs_raddr),
        .o_rdata (rs_rdata)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign load_out   = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    assign total_t = {{(TW-FW){1'b0}}, r_lf} + {{(TW-FW){1'b0}}, r_rf};
    assign pos_t   = {{(TW-POS_W){1'b0}}, i_position};
    assign lf_m1   = r_lf - ONE;
    assign rf_m1   = r_rf - ONE;
    assign lf_ext  = {{COUNT_W{1'b0}}, r_lf};
    assign rf_ext  = {{COUNT_W{1'b0}}, r_rf};

    always_comb begin
        n_state      = r_state;
        n_lf         = r_lf;
        n_rf         = r_rf;
        n_tgt        = r_tgt;
        n_pend       = r_pend;
        n_dir_right  = r_dir_right;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_lc     = r_out_lc;
        n_out_rc     = r_out_rc;
        n_out_cb     = r_out_cb;
        n_out_ca     = r_out_ca;
        l_we         = 1'b0;
        l_waddr      = r_lf[AW-1:0];
        l_wdata      = i_char_in;
        l_re         = 1'b0;
        l_raddr      = lf_m1[AW-1:0];
        rs_we        = 1'b0;
        rs_waddr     = r_rf[AW-1:0];
        rs_wdata     = l_rdata;
        rs_re        = 1'b0;
        rs_raddr     = rf_m1[AW-1:0];
        lf_eff       = r_lf;
        rf_eff       = r_rf;
        lf_eff_m1    = r_lf - ONE;
        rf_eff_m1    = r_rf - ONE;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state  = ST_FETCH;
                    n_status = STAT_OK;
                    case (i_command)
                        CMD_INSERT: begin
                            if (total_t >= DEPTH_T) begin
                                n_status = STAT_FULL;
                            end else begin
                                l_we = 1'b1;
                                n_lf = r_lf + ONE;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_rf == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_rf = rf_m1;
                            end
                        end
                        CMD_BACKSPACE: begin
                            if (r_lf == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                n_lf = lf_m1;
                            end
                        end
                        CMD_MOVE: begin
                            if (pos_t > total_t) begin
                                n_status = STAT_BADPOS;
                            end else begin
                                n_tgt   = pos_t[FW-1:0];
                                n_pend  = 1'b0;
                                n_state = ST_MOVE;
                            end
                        end
                        default: begin
                            n_status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_MOVE: begin
                if (r_pend) begin
                    if (r_dir_right) begin
                        rs_we    = 1'b1;
                        rs_wdata = l_rdata;
                        lf_eff   = r_lf - ONE;
                        rf_eff   = r_rf + ONE;
                    end else begin
                        l_we    = 1'b1;
                        l_wdata = rs_rdata;
                        lf_eff  = r_lf + ONE;
                        rf_eff  = r_rf - ONE;
                    end
                end
                lf_eff_m1 = lf_eff - ONE;
                rf_eff_m1 = rf_eff - ONE;
                n_lf      = lf_eff;
                n_rf      = rf_eff;
                if (lf_eff > r_tgt) begin
                    l_re        = 1'b1;
                    l_raddr     = lf_eff_m1[AW-1:0];
                    n_pend      = 1'b1;
                    n_dir_right = 1'b1;
                end else if (lf_eff < r_tgt) begin
                    rs_re       = 1'b1;
                    rs_raddr    = rf_eff_m1[AW-1:0];
                    n_pend      = 1'b1;
                    n_dir_right = 1'b0;
                end else begin
                    n_pend  = 1'b0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                l_re    = 1'b1;
                rs_re   = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (load_out) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_lc     = lf_ext[COUNT_W-1:0];
                    n_out_rc     = rf_ext[COUNT_W-1:0];
                    n_out_cb     = (r_lf != '0) ? l_rdata : '0;
                    n_out_ca     = (r_rf != '0) ? rs_rdata : '0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lf        <= '0;
            r_rf        <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lf        <= n_lf;
            r_rf        <= n_rf;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tgt        <= n_tgt;
        r_dir_right  <= n_dir_right;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_lc     <= n_out_lc;
        r_out_rc     <= n_out_rc;
        r_out_cb     <= n_out_cb;
        r_out_ca     <= n_out_ca;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_left_count  = r_out_lc;
    assign o_right_count = r_out_rc;
    assign o_char_before = r_out_cb;
    assign o_char_after  = r_out_ca;

endmodule

// File: tb/sv/two_stack_cursor_text_buffer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_cursor_text_buffer_checker
// Watches both channels of the cursor text buffer and checks every result.
//
// Each accepted command beat is applied to a private two-stack copy of the
// line, which yields the status, counts and neighbor characters that the
// block must return. Each accepted result beat is compared field by field
// with the oldest outstanding prediction. The number of mismatches, the
// number of outstanding predictions and the predicted text length are
// handed to the testbench top.
// ----------------------------------------------------------------------------
module two_stack_cursor_text_buffer_checker #(
    parameter int DEPTH = tscb_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [tscb_pkg::CMD_W-1:0]   i_command,
    input  logic [tscb_pkg::CHAR_W-1:0]  i_char_in,
    input  logic [tscb_pkg::POS_W-1:0]   i_position,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [tscb_pkg::STAT_W-1:0]  i_status,
    input  logic [tscb_pkg::COUNT_W-1:0] i_left_count,
    input  logic [tscb_pkg::COUNT_W-1:0] i_right_count,
    input  logic [tscb_pkg::CHAR_W-1:0]  i_char_before,
    input  logic [tscb_pkg::CHAR_W-1:0]  i_char_after,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_text_len
);
    import tscb_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] left_count;
        logic [COUNT_W-1:0] right_count;
        logic [CHAR_W-1:0]  char_before;
        logic [CHAR_W-1:0]  char_after;
    } t_cursor_view;

    logic [CHAR_W-1:0] chars_before_cursor [DEPTH];
    logic [CHAR_W-1:0] chars_after_cursor  [DEPTH];
    int unsigned       n_before;
    int unsigned       n_after;
    t_cursor_view      expected_views [$];
    int                fails = 0;

    function automatic t_cursor_view apply_edit(
        input logic [CMD_W-1:0]  cmd,
        input logic [CHAR_W-1:0] ch,
        input logic [POS_W-1:0]  pos
    );
        t_cursor_view view;
        int unsigned  total;
        total       = n_before + n_after;
        view.status = STAT_OK;
        case (cmd)
            CMD_INSERT: begin
                if (total >= DEPTH) begin
                    view.status = STAT_FULL;
                end else begin
                    chars_before_cursor[n_before] = ch;
                    n_before++;
                end
            end
            CMD_DELETE: begin
                if (n_after == 0) view.status = STAT_EMPTY;
                else n_after--;
            end
            CMD_BACKSPACE: begin
                if (n_before == 0) view.status = STAT_EMPTY;
                else n_before--;
            end
            CMD_MOVE: begin
                if (pos > total) begin
                    view.status = STAT_BADPOS;
                end else begin
                    while (n_before > pos) begin
                        n_before--;
                        chars_after_cursor[n_after] = chars_before_cursor[n_before];
                        n_after++;
                    end
                    while (n_before < pos) begin
                        n_after--;
                        chars_before_cursor[n_before] = chars_after_cursor[n_after];
                        n_before++;
                    end
                end
            end
        endcase
        view.left_count  = COUNT_W'(n_before);
        view.right_count = COUNT_W'(n_after);
        view.char_before = (n_before > 0) ? chars_before_cursor[n_before-1] : '0;
        view.char_after  = (n_after > 0) ? chars_after_cursor[n_after-1] : '0;
        return view;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        fails++;
    endtask

    task automatic compare_view(input t_cursor_view want);
        if (i_status !== want.status)
            report_mismatch("status", 16'(i_status), 16'(want.status));
        if (i_left_count !== want.left_count)
            report_mismatch("left_count", 16'(i_left_count), 16'(want.left_count));
        if (i_right_count !== want.right_count)
            report_mismatch("right_count", 16'(i_right_count), 16'(want.right_count));
        if (i_char_before !== want.char_before)
            report_mismatch("char_before", 16'(i_char_before), 16'(want.char_before));
        if (i_char_after !== want.char_after)
            report_mismatch("char_after", 16'(i_char_after), 16'(want.char_after));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_before = 0;
            n_after  = 0;
            expected_views.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_views.size() == 0)
                    report_mismatch("result beat with no command outstanding", 16'd1, 16'd0);
                else
                    compare_view(expected_views.pop_front());
            end
            if (i_in_valid && !i_in_stall)
                expected_views.push_back(apply_edit(i_command, i_char_in, i_position));
        end
        o_pending    <= expected_views.size();
        o_text_len   <= n_before + n_after;
        o_fail_count <= fails;
    end

endmodule

// File: tb/sv/two_stack_cursor_text_buffer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_cursor_text_buffer_unit_tb
// Stimulus and verdict for the two-stack cursor text buffer.
//
// A short directed sequence covers empty pops, bad and unchanged cursor
// positions and the field extremes. Random traffic follows: a mixed phase,
// a phase without gaps or stalls, a phase that grows the line with mostly
// inserts, and a phase that shrinks it again. Both channels see random gaps
// and stalls. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module two_stack_cursor_text_buffer_unit_tb;
    import tscb_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int QUIET_LIMIT = 8000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_command;
    logic [CHAR_W-1:0]  i_char_in;
    logic [POS_W-1:0]   i_position;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [STAT_W-1:0]  o_status;
    logic [COUNT_W-1:0] o_left_count;
    logic [COUNT_W-1:0] o_right_count;
    logic [CHAR_W-1:0]  o_char_before;
    logic [CHAR_W-1:0]  o_char_after;

    int   fail_count;
    int   pending;
    int   text_len;
    logic traffic_gaps;

    two_stack_cursor_text_buffer_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_in    (i_char_in),
        .i_position   (i_position),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_left_count (o_left_count),
        .o_right_count(o_right_count),
        .o_char_before(o_char_before),
        .o_char_after (o_char_after)
    );

    two_stack_cursor_text_buffer_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_char_in    (i_char_in),
        .i_position   (i_position),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_status     (o_status),
        .i_left_count (o_left_count),
        .i_right_count(o_right_count),
        .i_char_before(o_char_before),
        .i_char_after (o_char_after),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_text_len   (text_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!traffic_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int hold;
        hold        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else begin
                hold = pick_gap();
            end
            i_out_stall <= (hold > 0);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic issue_edit(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                              input logic [POS_W-1:0] pos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_char_in  <= ch;
        i_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(input int w_ins, input int w_del,
                                                      input int w_bsp);
        int r;
        r = $urandom_range(0, 99);
        if (r < w_ins) return CMD_INSERT;
        if (r < w_ins + w_del) return CMD_DELETE;
        if (r < w_ins + w_del + w_bsp) return CMD_BACKSPACE;
        return CMD_MOVE;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input int len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return POS_W'($urandom_range(0, 2047));
        if (r < 15) return POS_W'(len);
        if (r < 20) return '0;
        if (r < 25 && len < 2047) return POS_W'(len + 1);
        return POS_W'($urandom_range(0, len));
    endfunction

    task automatic random_edits(input int count, input int w_ins, input int w_del,
                                input int w_bsp);
        for (int k = 0; k < count; k++) begin
            issue_edit(pick_command(w_ins, w_del, w_bsp), CHAR_W'($urandom),
                       pick_position(text_len));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_INSERT;
        i_char_in    = '0;
        i_position   = '0;
        traffic_gaps = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue_edit(CMD_BACKSPACE, 8'hFF, 11'd2047);
        issue_edit(CMD_DELETE,    8'h00, 11'd0);
        issue_edit(CMD_MOVE,      8'h00, 11'd0);
        issue_edit(CMD_MOVE,      8'h00, 11'd1);
        issue_edit(CMD_MOVE,      8'hFF, 11'd2047);
        issue_edit(CMD_INSERT,    8'h00, 11'd2047);
        issue_edit(CMD_INSERT,    8'hFF, 11'd0);
        issue_edit(CMD_INSERT,    8'hA5, 11'd1024);
        issue_edit(CMD_INSERT,    8'h5A, 11'd0);
        issue_edit(CMD_MOVE,      8'h00, 11'd0);
        issue_edit(CMD_MOVE,      8'h00, 11'd4);
        issue_edit(CMD_MOVE,      8'h00, 11'd2);
        issue_edit(CMD_MOVE,      8'h00, 11'd2);
        issue_edit(CMD_MOVE,      8'h00, 11'd5);
        issue_edit(CMD_DELETE,    8'hFF, 11'd2047);
        issue_edit(CMD_BACKSPACE, 8'h00, 11'd0);
        issue_edit(CMD_MOVE,      8'h00, 11'd0);
        issue_edit(CMD_DELETE,    8'h00, 11'd0);
        issue_edit(CMD_DELETE,    8'h00, 11'd0);
        issue_edit(CMD_BACKSPACE, 8'h00, 11'd0);
        hold_until_drained();

        random_edits(300, 40, 15, 15);
        hold_until_drained();

        traffic_gaps = 1'b0;
        random_edits(80, 40, 15, 15);
        traffic_gaps = 1'b1;

        random_edits(200, 88, 3, 3);
        hold_until_drained();

        random_edits(200, 10, 40, 40);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tscb_pkg.sv
hw/rtl/tscb_ram.sv
hw/rtl/two_stack_cursor_text_buffer_unit.sv
tb/sv/two_stack_cursor_text_buffer_checker.sv
tb/sv/two_stack_cursor_text_buffer_unit_tb.sv
